FILE: src/radar_status_frame_decoder_top_macros.svh
// Assertion macros for the radar status frame decoder.
`ifndef RADAR_STATUS_FRAME_DECODER_TOP_MACROS_SVH
`define RADAR_STATUS_FRAME_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RSFD_ASSERT_ALWAYS(name, expr) \
name: assert property (@(posedge clock) disable iff (reset) (expr)) \
   else $error("rsfd assertion failed");
`define RSFD_ASSERT_NEXT(name, ante, cons) \
name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("rsfd assertion failed");
`else
`define RSFD_ASSERT_ALWAYS(name, expr)
`define RSFD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

FILE: src/rsfd_pkg.sv
// Types, constants and field codes shared by the radar status frame decoder.
`default_nettype none
package rsfd_pkg;

   localparam int RSFD_FRAME_BYTES = 32;
   localparam int WIN_BYTES        = 18;
   localparam int MAX_RECS         = 11;

   localparam logic [7:0] MIN_FRAME   = 8'd9;
   localparam logic [7:0] HDR0        = 8'h53;
   localparam logic [7:0] HDR1        = 8'h59;
   localparam logic [4:0] WAVE_FIRST  = 5'd6;
   localparam logic [4:0] WAVE_LAST   = 5'd10;
   localparam logic [4:0] NIGHT_APNEA = 5'd17;

   localparam logic [15:0] LEN_DUR    = 16'd2;
   localparam logic [15:0] LEN_WAVE   = 16'd5;
   localparam logic [15:0] LEN_COORD  = 16'd6;
   localparam logic [15:0] LEN_COMP   = 16'd8;
   localparam logic [15:0] LEN_NIGHT  = 16'd12;

   // floor(s/5) = (s*1639) >> 13 for s up to 5*255
   localparam logic [21:0] DIV5_MUL   = 22'd1639;
   localparam int          DIV5_SHIFT = 13;

   // control bytes
   localparam logic [7:0] CTRL_HUMAN  = 8'h80;
   localparam logic [7:0] CTRL_BREATH = 8'h81;
   localparam logic [7:0] CTRL_SLEEP  = 8'h84;
   localparam logic [7:0] CTRL_HEART  = 8'h85;

   // command bytes
   localparam logic [7:0] CMD_PRESENCE     = 8'h01;
   localparam logic [7:0] CMD_MOTION       = 8'h02;
   localparam logic [7:0] CMD_AMPLITUDE    = 8'h03;
   localparam logic [7:0] CMD_DISTANCE     = 8'h04;
   localparam logic [7:0] CMD_POSITION     = 8'h05;
   localparam logic [7:0] CMD_BR_STATUS    = 8'h01;
   localparam logic [7:0] CMD_BR_RATE      = 8'h02;
   localparam logic [7:0] CMD_WAVE         = 8'h05;
   localparam logic [7:0] CMD_BED          = 8'h01;
   localparam logic [7:0] CMD_SLEEP_STATE  = 8'h02;
   localparam logic [7:0] CMD_AWAKE_TIME   = 8'h03;
   localparam logic [7:0] CMD_LIGHT_TIME   = 8'h04;
   localparam logic [7:0] CMD_DEEP_TIME    = 8'h05;
   localparam logic [7:0] CMD_SLEEP_SCORE  = 8'h06;
   localparam logic [7:0] CMD_COMPOSITE    = 8'h0C;
   localparam logic [7:0] CMD_NIGHT_REPORT = 8'h0D;
   localparam logic [7:0] CMD_ABNORMAL     = 8'h0E;
   localparam logic [7:0] CMD_GRADE        = 8'h10;
   localparam logic [7:0] CMD_STRUGGLE     = 8'h11;
   localparam logic [7:0] CMD_NOPERSON     = 8'h12;
   localparam logic [7:0] CMD_HEART_RATE   = 8'h02;

   // field ids
   localparam logic [5:0] FID_PRESENCE     = 6'd0;
   localparam logic [5:0] FID_BODY_STATUS  = 6'd1;
   localparam logic [5:0] FID_MOVE_AMP     = 6'd2;
   localparam logic [5:0] FID_DISTANCE     = 6'd3;
   localparam logic [5:0] FID_HUMAN_X      = 6'd4;
   localparam logic [5:0] FID_HUMAN_Y      = 6'd5;
   localparam logic [5:0] FID_HUMAN_Z      = 6'd6;
   localparam logic [5:0] FID_BR_STATUS    = 6'd7;
   localparam logic [5:0] FID_BR_RATE      = 6'd8;
   localparam logic [5:0] FID_BR_WAVE_AVG  = 6'd9;
   localparam logic [5:0] FID_BED          = 6'd10;
   localparam logic [5:0] FID_SLEEP_QUAL   = 6'd11;
   localparam logic [5:0] FID_AWAKE_DUR    = 6'd12;
   localparam logic [5:0] FID_SLEEP_SCORE  = 6'd15;
   localparam logic [5:0] FID_AVG_BREATH   = 6'd16;
   localparam logic [5:0] FID_APNEA        = 6'd21;
   localparam logic [5:0] FID_SLEEP_TOTAL  = 6'd22;
   localparam logic [5:0] FID_AWAKE_RATIO  = 6'd23;
   localparam logic [5:0] FID_ABNORMAL     = 6'd31;
   localparam logic [5:0] FID_GRADE        = 6'd32;
   localparam logic [5:0] FID_STRUGGLE     = 6'd33;
   localparam logic [5:0] FID_NOPERSON     = 6'd34;
   localparam logic [5:0] FID_HEART_RATE   = 6'd35;
   localparam logic [5:0] FID_HT_WAVE_AVG  = 6'd36;
   localparam logic [5:0] FID_HT_WAVE0     = 6'd37;
   localparam logic [5:0] FID_BR_WAVE0     = 6'd42;

   // sleep quality code meaning "no sleep / out of bed"
   localparam logic [7:0] QUAL_NONE = 8'd3;

   typedef logic [WIN_BYTES-1:0][7:0] win_type;

   typedef struct packed {
      logic [3:0]         count;
      logic [5:0]         field_id;
      logic signed [16:0] value;
   } rec_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

FILE: src/rsfd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module rsfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/rsfd_rec.sv
// Record table: count, field id and value of record k for the loaded frame window.
`default_nettype none
module rsfd_rec
   import rsfd_pkg::*;
(
   input  win_type     win,
   input  logic [10:0] wave_sum,
   input  logic [3:0]  rec_k,
   output rec_sel_type sel
);

   logic [7:0]         ctrl;
   logic [7:0]         cmd;
   logic [15:0]        len;
   logic [7:0]         d0;
   logic [7:0]         b7;
   logic               hdr_ok;
   logic               is_wave;
   logic [4:0]         pos;
   logic [7:0]         pbyte;
   logic [16:0]        pbyte_x;
   logic [16:0]        d0_x;
   logic [16:0]        dur_x;
   logic [15:0]        craw;
   logic signed [16:0] coord;
   logic [21:0]        prod;
   logic [16:0]        avg_x;

   assign ctrl   = win[2];
   assign cmd    = win[3];
   assign len    = {win[4], win[5]};
   assign d0     = win[6];
   assign b7     = win[7];
   assign hdr_ok = (win[0] == HDR0) && (win[1] == HDR1);
   assign d0_x   = {9'd0, d0};
   assign dur_x  = (len >= LEN_DUR) ? {1'b0, win[6], win[7]} : d0_x;
   assign is_wave = (cmd == CMD_WAVE) && ((ctrl == CTRL_BREATH) || (ctrl == CTRL_HEART));

   assign prod  = 22'(wave_sum) * DIV5_MUL;
   assign avg_x = 17'(prod[21:DIV5_SHIFT]);

   // one byte position chosen per record for the list-style commands
   always_comb begin
      pos = WAVE_FIRST;
      if (is_wave) begin
         pos = WAVE_FIRST + 5'(rec_k);
      end else if (ctrl == CTRL_SLEEP && cmd == CMD_COMPOSITE) begin
         pos = 5'd5 + 5'(rec_k);
      end else if (ctrl == CTRL_SLEEP && cmd == CMD_NIGHT_REPORT) begin
         pos = (rec_k == 4'd10) ? NIGHT_APNEA : 5'd7 + 5'(rec_k);
      end
   end

   assign pbyte   = (32'(pos) < WIN_BYTES) ? win[pos] : 8'd0;
   assign pbyte_x = {9'd0, pbyte};

   // coordinate pairs at byte 6, 8, 10
   always_comb begin
      case (rec_k)
         4'd0:    craw = {win[6], win[7]};
         4'd1:    craw = {win[8], win[9]};
         default: craw = {win[10], win[11]};
      endcase
      coord = craw[15] ? -$signed({2'b00, craw[14:0]}) : $signed({2'b00, craw[14:0]});
   end

   always_comb begin
      sel.count    = 4'd0;
      sel.field_id = FID_PRESENCE;
      sel.value    = '0;
      case (ctrl)
         CTRL_HUMAN: begin
            case (cmd)
               CMD_PRESENCE: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_PRESENCE;
                  sel.value = (d0 == 8'd1) ? 17'sd1 : 17'sd0;
               end
               CMD_MOTION: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_BODY_STATUS;
                  sel.value = (d0 == 8'd2) ? 17'sd1 : 17'sd0;
               end
               CMD_AMPLITUDE: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_MOVE_AMP;
                  sel.value = d0_x;
               end
               CMD_DISTANCE: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_DISTANCE;
                  sel.value = dur_x;
               end
               CMD_POSITION: begin
                  if (len >= LEN_COORD) begin
                     sel.count = 4'd3;
                     sel.field_id = (rec_k == 4'd0) ? FID_HUMAN_X :
                                    (rec_k == 4'd1) ? FID_HUMAN_Y : FID_HUMAN_Z;
                     sel.value = coord;
                  end
               end
               default: ;
            endcase
         end
         CTRL_BREATH: begin
            case (cmd)
               CMD_BR_STATUS: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_BR_STATUS;
                  sel.value = d0_x;
               end
               CMD_BR_RATE: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_BR_RATE;
                  sel.value = d0_x;
               end
               CMD_WAVE: begin
                  if (len >= LEN_WAVE) begin
                     sel.count = 4'd6;
                     sel.field_id = (rec_k == 4'd5) ? FID_BR_WAVE_AVG
                                                    : FID_BR_WAVE0 + 6'(rec_k);
                     sel.value = (rec_k == 4'd5) ? avg_x : pbyte_x;
                  end
               end
               default: ;
            endcase
         end
         CTRL_SLEEP: begin
            case (cmd)
               CMD_BED: begin
                  if (d0 == 8'd0) begin
                     sel.count = 4'd2;
                     sel.field_id = (rec_k == 4'd0) ? FID_BED : FID_SLEEP_QUAL;
                     sel.value = (rec_k == 4'd0) ? 17'sd0 : 17'(QUAL_NONE);
                  end else if (d0 == 8'd1) begin
                     sel.count = 4'd1;
                     sel.field_id = FID_BED;
                     sel.value = 17'sd1;
                  end
               end
               CMD_SLEEP_STATE: begin
                  sel.count = 4'd2;
                  sel.field_id = (rec_k == 4'd0) ? FID_SLEEP_QUAL : FID_BED;
                  if (d0 <= 8'd2) begin
                     sel.value = (rec_k == 4'd0) ? d0_x : 17'sd1;
                  end else begin
                     sel.value = (rec_k == 4'd0) ? 17'(QUAL_NONE) : 17'sd0;
                  end
               end
               CMD_AWAKE_TIME, CMD_LIGHT_TIME, CMD_DEEP_TIME: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_AWAKE_DUR + 6'(cmd - CMD_AWAKE_TIME);
                  sel.value = dur_x;
               end
               CMD_SLEEP_SCORE: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_SLEEP_SCORE;
                  sel.value = d0_x;
               end
               CMD_COMPOSITE: begin
                  if (len >= LEN_COMP) begin
                     sel.count = 4'd9;
                     case (rec_k)
                        4'd0: begin
                           sel.field_id = FID_PRESENCE;
                           sel.value = (d0 != 8'd0) ? 17'sd1 : 17'sd0;
                        end
                        4'd1: begin
                           sel.field_id = FID_SLEEP_QUAL;
                           sel.value = {9'd0, b7};
                        end
                        4'd2: begin
                           sel.field_id = FID_BED;
                           sel.value = (b7 == QUAL_NONE) ? 17'sd0 : 17'sd1;
                        end
                        default: begin
                           sel.field_id = FID_AVG_BREATH + 6'(rec_k - 4'd3);
                           sel.value = pbyte_x;
                        end
                     endcase
                  end
               end
               CMD_NIGHT_REPORT: begin
                  if (len >= LEN_NIGHT) begin
                     sel.count = 4'd11;
                     case (rec_k)
                        4'd0: begin
                           sel.field_id = FID_SLEEP_SCORE;
                           sel.value = d0_x;
                        end
                        4'd1: begin
                           sel.field_id = FID_SLEEP_TOTAL;
                           sel.value = {1'b0, win[7], win[8]};
                        end
                        4'd10: begin
                           sel.field_id = FID_APNEA;
                           sel.value = pbyte_x;
                        end
                        default: begin
                           sel.field_id = FID_AWAKE_RATIO + 6'(rec_k - 4'd2);
                           sel.value = pbyte_x;
                        end
                     endcase
                  end
               end
               CMD_ABNORMAL: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_ABNORMAL;
                  sel.value = d0_x;
               end
               CMD_GRADE: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_GRADE;
                  sel.value = d0_x;
               end
               CMD_STRUGGLE: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_STRUGGLE;
                  sel.value = d0_x;
               end
               CMD_NOPERSON: begin
                  sel.count = 4'd1;
                  sel.field_id = FID_NOPERSON;
                  sel.value = d0_x;
               end
               default: ;
            endcase
         end
         CTRL_HEART: begin
            case (cmd)
               CMD_HEART_RATE: begin
                  // nonzero rate also marks presence
                  sel.count = (d0 != 8'd0) ? 4'd2 : 4'd1;
                  sel.field_id = (rec_k == 4'd0) ? FID_HEART_RATE : FID_PRESENCE;
                  sel.value = (rec_k == 4'd0) ? d0_x : 17'sd1;
               end
               CMD_WAVE: begin
                  if (len >= LEN_WAVE) begin
                     sel.count = 4'd6;
                     sel.field_id = (rec_k == 4'd5) ? FID_HT_WAVE_AVG
                                                    : FID_HT_WAVE0 + 6'(rec_k);
                     sel.value = (rec_k == 4'd5) ? avg_x : pbyte_x;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      if (!hdr_ok) begin
         sel.count = 4'd0;
      end
   end

endmodule
`default_nettype wire

FILE: src/radar_status_frame_decoder_top.sv
// Radar status frame decoder: banked frame RAM, window load sequencer, record output.
// Bytes are taken one per cycle; each frame is written to one bank of the frame RAM.
// A closed frame of 9+ bytes is read back into an 18-byte window (one RAM read port), then its
// records leave one per cycle while the output is not stalled.
// A closing byte waits while the previous frame still decodes; other bytes never wait.
// Synchronous reset empties the byte count and idles the sequencer; RAM is not cleared.
`default_nettype none
`include "radar_status_frame_decoder_top_macros.svh"
module radar_status_frame_decoder_top
   import rsfd_pkg::*;
#(
   parameter int FRAME_BYTES = RSFD_FRAME_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [5:0] field_id, [22:6] value, [23] zero
   output logic        rsp_tlast    // last
);

   localparam int AW = $clog2(2 * FRAME_BYTES);
   localparam int PW = $clog2(FRAME_BYTES);
   localparam logic [8:0] FB9 = 9'(FRAME_BYTES);

   // write side
   logic [7:0]    byte_count_ff, byte_count_in;
   logic          wr_bank_ff, wr_bank_in;
   logic          req_fire;
   logic          frame_close;
   logic          in_store;
   logic [7:0]    count_next;
   logic [AW-1:0] wr_addr;

   // sequencer
   state_type     state_ff, state_in;
   logic          rd_bank_ff;
   logic [7:0]    frame_len_ff;
   logic [4:0]    rd_idx_ff;
   logic          rd_vld_ff;
   logic [4:0]    rd_pos_ff;
   logic          rd_issue;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [7:0]    rd_byte;
   win_type       win_ff;
   logic [10:0]   sum_ff;
   logic [3:0]    rec_k_ff;
   rec_sel_type   sel;
   logic          emit_take;
   logic          rec_last;
   logic          load_done;

   // output register
   logic               rsp_valid_ff;
   logic [5:0]         rsp_id_ff;
   logic signed [16:0] rsp_value_ff;
   logic               rsp_last_ff;

   assign req_tready  = !(req_tlast && state_ff != ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign frame_close = req_fire && req_tlast;
   assign in_store    = {1'b0, byte_count_ff} < FB9;
   assign count_next  = (byte_count_ff == 8'hFF) ? 8'hFF : byte_count_ff + 8'd1;
   assign wr_addr     = wr_bank_ff ? AW'(FRAME_BYTES) + AW'(byte_count_ff[PW-1:0])
                                   : AW'(byte_count_ff[PW-1:0]);
   assign rd_addr     = rd_bank_ff ? AW'(FRAME_BYTES) + AW'(rd_idx_ff) : AW'(rd_idx_ff);

   always_comb begin
      byte_count_in = byte_count_ff;
      wr_bank_in    = wr_bank_ff;
      if (req_fire) begin
         byte_count_in = req_tlast ? 8'd0 : count_next;
         wr_bank_in    = wr_bank_ff ^ req_tlast;
      end
   end

   rsfd_ram #(
      .WIDTH (8),
      .DEPTH (2 * FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (req_fire && in_store),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // bytes beyond the received count read as zero
   assign rd_byte   = ({3'd0, rd_pos_ff} < frame_len_ff) ? rd_data : 8'd0;
   assign load_done = rd_vld_ff && (32'(rd_pos_ff) == WIN_BYTES - 1);

   rsfd_rec u_rec (
      .win      (win_ff),
      .wave_sum (sum_ff),
      .rec_k    (rec_k_ff),
      .sel      (sel)
   );

   assign rec_last = (rec_k_ff == sel.count - 4'd1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (frame_close && count_next >= MIN_FRAME) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (load_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sel.count == 4'd0 || (emit_take && rec_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      rd_issue  = 1'b0;
      emit_take = 1'b0;
      case (state_ff)
         ST_LOAD: rd_issue  = 32'(rd_idx_ff) < WIN_BYTES;
         ST_EMIT: emit_take = (sel.count != 4'd0) && (!rsp_valid_ff || rsp_tready);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 8'd0;
         wr_bank_ff    <= 1'b0;
         state_ff      <= ST_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rd_idx_ff     <= 5'd0;
         rec_k_ff      <= 4'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         wr_bank_ff    <= wr_bank_in;
         state_ff      <= state_in;
         rd_vld_ff     <= rd_issue;
         if (state_ff == ST_IDLE) begin
            rd_idx_ff <= 5'd0;
            rec_k_ff  <= 4'd0;
         end else begin
            if (rd_issue) begin
               rd_idx_ff <= rd_idx_ff + 5'd1;
            end
            if (emit_take) begin
               rec_k_ff <= rec_k_ff + 4'd1;
            end
         end
         if (emit_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && frame_close) begin
         rd_bank_ff   <= wr_bank_ff;
         frame_len_ff <= count_next;
         sum_ff       <= 11'd0;
      end else if (rd_vld_ff && rd_pos_ff >= WAVE_FIRST && rd_pos_ff <= WAVE_LAST) begin
         sum_ff <= sum_ff + 11'(rd_byte);
      end
      rd_pos_ff <= rd_idx_ff;
      if (rd_vld_ff) begin
         win_ff[rd_pos_ff] <= rd_byte;
      end
      if (emit_take) begin
         rsp_id_ff    <= sel.field_id;
         rsp_value_ff <= sel.value;
         rsp_last_ff  <= rec_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

   `RSFD_ASSERT_ALWAYS(a_no_close_while_busy, !(frame_close && state_ff != ST_IDLE))
   `RSFD_ASSERT_ALWAYS(a_read_only_in_load, !rd_vld_ff || state_ff == ST_LOAD)
   `RSFD_ASSERT_NEXT(a_last_rec_ends_frame, emit_take && rec_last, state_ff == ST_IDLE && rsp_tlast)

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for radar_status_frame_decoder_top: directed and random frames.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rsfd_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 60;
   localparam int RANDOM_BYTES = 310;
   localparam int DATA_POS     = 6;

   localparam logic [7:0] CTRL_UNUSED = 8'h82;
   localparam logic [7:0] CMD_UNUSED  = 8'h7F;
   localparam logic [7:0] TAIL0       = 8'h54;
   localparam logic [7:0] TAIL1       = 8'h43;

   typedef logic [7:0] byte_q_type [$];

   typedef struct {
      logic [5:0]         field_id;
      logic signed [16:0] value;
      logic               last;
   } status_update_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] rx_byte
   logic        req_tlast;   // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [5:0] field_id, [22:6] value, [23] zero
   logic        rsp_tlast;   // last

   status_update_type expected_updates [$];
   status_update_type frame_updates [$];
   logic [7:0]     rx_store [RSFD_FRAME_BYTES];
   int unsigned    rx_count;
   bit             no_idle;
   int             mismatches;
   int             cycles;

   radar_status_frame_decoder_top #(
      .FRAME_BYTES(RSFD_FRAME_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned frame_byte(int unsigned pos);
      return (pos < RSFD_FRAME_BYTES) ? rx_store[pos] : 0;
   endfunction

   function automatic int unsigned be_word(int unsigned pos);
      return (frame_byte(pos) << 8) | frame_byte(pos + 1);
   endfunction

   // sign-magnitude: bit 15 flags a negative magnitude in bits 14..0
   function automatic int signed_coord(int unsigned pos);
      int unsigned raw;
      int          mag;
      raw = be_word(pos);
      mag = int'(raw & 32'h7FFF);
      return raw[15] ? -mag : mag;
   endfunction

   function automatic void add_update(int unsigned id, int v);
      status_update_type u;
      if (frame_updates.size() >= MAX_RECS) return;
      u.field_id = id[5:0];
      u.value    = v[16:0];
      u.last     = 1'b0;
      frame_updates.push_back(u);
   endfunction

   function automatic void add_wave(int unsigned first_id, int unsigned avg_id);
      int unsigned sum;
      int          i;
      sum = 0;
      for (i = 0; i < 5; i++) begin
         add_update(first_id + i, frame_byte(DATA_POS + i));
         sum += frame_byte(DATA_POS + i);
      end
      add_update(avg_id, sum / 5);
   endfunction

   function automatic void add_sleep_state(int unsigned qual);
      if (qual == QUAL_NONE) begin
         add_update(FID_SLEEP_QUAL, QUAL_NONE);
         add_update(FID_BED, 0);
      end else begin
         add_update(FID_SLEEP_QUAL, qual);
         add_update(FID_BED, 1);
      end
   endfunction

   function automatic void decode_status(int unsigned count);
      int unsigned ctrl, cmd, len, d0, dur;
      int          i;
      if (count < MIN_FRAME) return;
      if (frame_byte(0) != HDR0 || frame_byte(1) != HDR1) return;
      ctrl = frame_byte(2);
      cmd  = frame_byte(3);
      len  = be_word(4);
      d0   = frame_byte(DATA_POS);
      dur  = (len >= LEN_DUR) ? be_word(DATA_POS) : d0;
      case (ctrl)
         CTRL_HUMAN: begin
            case (cmd)
               CMD_PRESENCE:  add_update(FID_PRESENCE, d0 == 1);
               CMD_MOTION:    add_update(FID_BODY_STATUS, d0 == 2);
               CMD_AMPLITUDE: add_update(FID_MOVE_AMP, d0);
               CMD_DISTANCE:  add_update(FID_DISTANCE, dur);
               CMD_POSITION: begin
                  if (len >= LEN_COORD) begin
                     add_update(FID_HUMAN_X, signed_coord(6));
                     add_update(FID_HUMAN_Y, signed_coord(8));
                     add_update(FID_HUMAN_Z, signed_coord(10));
                  end
               end
               default: ;
            endcase
         end
         CTRL_BREATH: begin
            case (cmd)
               CMD_BR_STATUS: add_update(FID_BR_STATUS, d0);
               CMD_BR_RATE:   add_update(FID_BR_RATE, d0);
               CMD_WAVE:      if (len >= LEN_WAVE) add_wave(FID_BR_WAVE0, FID_BR_WAVE_AVG);
               default: ;
            endcase
         end
         CTRL_SLEEP: begin
            case (cmd)
               CMD_BED: begin
                  if (d0 == 0) begin
                     add_update(FID_BED, 0);
                     add_update(FID_SLEEP_QUAL, QUAL_NONE);
                  end else if (d0 == 1) begin
                     add_update(FID_BED, 1);
                  end
               end
               CMD_SLEEP_STATE: add_sleep_state(d0 <= 2 ? d0 : QUAL_NONE);
               CMD_AWAKE_TIME, CMD_LIGHT_TIME, CMD_DEEP_TIME:
                  add_update(FID_AWAKE_DUR + cmd - CMD_AWAKE_TIME, dur);
               CMD_SLEEP_SCORE: add_update(FID_SLEEP_SCORE, d0);
               CMD_COMPOSITE: begin
                  if (len >= LEN_COMP) begin
                     add_update(FID_PRESENCE, d0 != 0);
                     add_sleep_state(frame_byte(7));
                     for (i = 0; i < 6; i++) add_update(FID_AVG_BREATH + i, frame_byte(8 + i));
                  end
               end
               CMD_NIGHT_REPORT: begin
                  if (len >= LEN_NIGHT) begin
                     add_update(FID_SLEEP_SCORE, d0);
                     add_update(FID_SLEEP_TOTAL, be_word(7));
                     for (i = 0; i < 8; i++) add_update(FID_AWAKE_RATIO + i, frame_byte(9 + i));
                     add_update(FID_APNEA, frame_byte(NIGHT_APNEA));
                  end
               end
               CMD_ABNORMAL: add_update(FID_ABNORMAL, d0);
               CMD_GRADE:    add_update(FID_GRADE, d0);
               CMD_STRUGGLE: add_update(FID_STRUGGLE, d0);
               CMD_NOPERSON: add_update(FID_NOPERSON, d0);
               default: ;
            endcase
         end
         CTRL_HEART: begin
            case (cmd)
               CMD_HEART_RATE: begin
                  add_update(FID_HEART_RATE, d0);
                  if (d0 > 0) add_update(FID_PRESENCE, 1);
               end
               CMD_WAVE: if (len >= LEN_WAVE) add_wave(FID_HT_WAVE0, FID_HT_WAVE_AVG);
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_byte(logic [7:0] b, logic closes);
      int i;
      if (rx_count < RSFD_FRAME_BYTES) rx_store[rx_count] = b;
      if (rx_count < 255) rx_count++;
      if (!closes) return;
      frame_updates.delete();
      decode_status(rx_count);
      if (frame_updates.size() > 0) frame_updates[frame_updates.size() - 1].last = 1'b1;
      foreach (frame_updates[i]) expected_updates.push_back(frame_updates[i]);
      rx_count = 0;
      for (i = 0; i < RSFD_FRAME_BYTES; i++) rx_store[i] = 8'h00;
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic send_byte(input logic [7:0] b, input logic closes);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= closes;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_byte(b, closes);
   endtask

   task automatic send_frame(input byte_q_type f);
      int i;
      for (i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
   endtask

   function automatic byte_q_type build_frame(logic [7:0] ctrl, logic [7:0] cmd,
                                              logic [15:0] len, byte_q_type data);
      byte_q_type f;
      logic [7:0] sum;
      int         i;
      f = {HDR0, HDR1, ctrl, cmd, len[15:8], len[7:0]};
      f = {f, data};
      sum = 8'h00;
      for (i = 0; i < f.size(); i++) sum += f[i];
      f.push_back(sum);
      f.push_back(TAIL0);
      f.push_back(TAIL1);
      return f;
   endfunction

   task automatic send_cmd(input logic [7:0] ctrl, input logic [7:0] cmd,
                           input logic [15:0] len, input byte_q_type data);
      send_frame(build_frame(ctrl, cmd, len, data));
   endtask

   // drop valid, then hold off until every update has come back
   task automatic wait_for_updates();
      req_tvalid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_framing();
      no_idle = 1'b0;
      send_frame({HDR0, HDR1, CTRL_HUMAN, CMD_PRESENCE, 8'h00, 8'h01, 8'h01, 8'hA7});
      send_frame({HDR0, HDR1, CTRL_HUMAN, CMD_PRESENCE, 8'h00, 8'h01, 8'h01, 8'hA7, TAIL0});
      send_frame({8'h52, HDR1, CTRL_HUMAN, CMD_PRESENCE, 8'h00, 8'h01, 8'h01, 8'hA7, TAIL0});
      send_frame({HDR0, 8'h58, CTRL_HUMAN, CMD_PRESENCE, 8'h00, 8'h01, 8'h01, 8'hA7, TAIL0});
      send_frame({8'hFF});
      send_cmd(CTRL_UNUSED, CMD_PRESENCE, 1, {8'h01});
   endtask

   task automatic test_human();
      no_idle = 1'b1;
      send_cmd(CTRL_HUMAN, CMD_PRESENCE, 1, {8'h00});
      send_cmd(CTRL_HUMAN, CMD_PRESENCE, 1, {8'h02});
      send_cmd(CTRL_HUMAN, CMD_MOTION, 1, {8'h02});
      send_cmd(CTRL_HUMAN, CMD_MOTION, 1, {8'hFF});
      send_cmd(CTRL_HUMAN, CMD_AMPLITUDE, 1, {8'hFF});
      send_cmd(CTRL_HUMAN, CMD_DISTANCE, 2, {8'hFF, 8'hFF});
      send_cmd(CTRL_HUMAN, CMD_DISTANCE, 1, {8'h80, 8'h01});
      send_cmd(CTRL_HUMAN, CMD_POSITION, 6, {8'h80, 8'h00, 8'hFF, 8'hFF, 8'h7F, 8'hFF});
      send_cmd(CTRL_HUMAN, CMD_POSITION, 6, {8'h00, 8'h01, 8'h80, 8'h01, 8'h00, 8'h00});
      send_cmd(CTRL_HUMAN, CMD_POSITION, 5, {8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC});
      send_cmd(CTRL_HUMAN, CMD_UNUSED, 1, {8'h01});
   endtask

   task automatic test_breath();
      no_idle = 1'b0;
      send_cmd(CTRL_BREATH, CMD_BR_STATUS, 1, {8'hFF});
      send_cmd(CTRL_BREATH, CMD_BR_RATE, 1, {8'h00});
      send_cmd(CTRL_BREATH, CMD_WAVE, 5, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_cmd(CTRL_BREATH, CMD_WAVE, 16'hFFFF, {8'h01, 8'h01, 8'h01, 8'h01, 8'h00});
      send_cmd(CTRL_BREATH, CMD_WAVE, 4, {8'h10, 8'h20, 8'h30, 8'h40, 8'h50});
   endtask

   task automatic test_sleep();
      no_idle = 1'b0;
      send_cmd(CTRL_SLEEP, CMD_BED, 1, {8'h00});
      send_cmd(CTRL_SLEEP, CMD_BED, 1, {8'h01});
      send_cmd(CTRL_SLEEP, CMD_BED, 1, {8'h02});
      send_cmd(CTRL_SLEEP, CMD_SLEEP_STATE, 1, {8'h00});
      send_cmd(CTRL_SLEEP, CMD_SLEEP_STATE, 1, {8'h02});
      send_cmd(CTRL_SLEEP, CMD_SLEEP_STATE, 1, {8'h03});
      send_cmd(CTRL_SLEEP, CMD_SLEEP_STATE, 1, {8'hFF});
      send_cmd(CTRL_SLEEP, CMD_AWAKE_TIME, 2, {8'hFF, 8'hFF});
      send_cmd(CTRL_SLEEP, CMD_LIGHT_TIME, 1, {8'h7E, 8'h55});
      send_cmd(CTRL_SLEEP, CMD_DEEP_TIME, 0, {8'hC3});
      send_cmd(CTRL_SLEEP, CMD_SLEEP_SCORE, 1, {8'h64});
      send_cmd(CTRL_SLEEP, CMD_COMPOSITE, 8,
               {8'h00, 8'h03, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hFF});
      send_cmd(CTRL_SLEEP, CMD_COMPOSITE, 8,
               {8'hFF, 8'h01, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
      send_cmd(CTRL_SLEEP, CMD_COMPOSITE, 7,
               {8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
      send_cmd(CTRL_SLEEP, CMD_NIGHT_REPORT, 12,
               {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_cmd(CTRL_SLEEP, CMD_NIGHT_REPORT, 11,
               {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C});
      send_cmd(CTRL_SLEEP, CMD_ABNORMAL, 1, {8'h02});
      send_cmd(CTRL_SLEEP, CMD_GRADE, 1, {8'h01});
      send_cmd(CTRL_SLEEP, CMD_STRUGGLE, 1, {8'h80});
      send_cmd(CTRL_SLEEP, CMD_NOPERSON, 1, {8'h7F});
      send_cmd(CTRL_SLEEP, CMD_UNUSED, 1, {8'h01});
   endtask

   task automatic test_heart();
      no_idle = 1'b1;
      send_cmd(CTRL_HEART, CMD_HEART_RATE, 1, {8'h00});
      send_cmd(CTRL_HEART, CMD_HEART_RATE, 1, {8'hFF});
      send_cmd(CTRL_HEART, CMD_WAVE, 5, {8'h00, 8'h00, 8'h00, 8'h00, 8'h04});
      send_cmd(CTRL_HEART, CMD_WAVE, 4, {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
   endtask

   // overlong frames, a frame read past its end, and a byte count past 255
   task automatic test_frame_store();
      byte_q_type data;
      int         i;
      no_idle = 1'b0;
      data.delete();
      for (i = 0; i < 31; i++) data.push_back(8'hFF);
      send_cmd(CTRL_SLEEP, CMD_NIGHT_REPORT, 12, data);
      send_frame({HDR0, HDR1, CTRL_SLEEP, CMD_NIGHT_REPORT, 8'h00, 8'h0C, 8'h55, 8'h01, 8'h02});
      no_idle = 1'b1;
      data.delete();
      for (i = 0; i < 251; i++) data.push_back(8'($urandom_range(0, 255)));
      send_cmd(CTRL_SLEEP, CMD_NIGHT_REPORT, 12, data);
   endtask

   function automatic int payload_len(logic [7:0] ctrl, logic [7:0] cmd);
      case (ctrl)
         CTRL_HUMAN: begin
            if (cmd == CMD_POSITION) return LEN_COORD;
            if (cmd == CMD_DISTANCE) return $urandom_range(1, 2);
         end
         CTRL_BREATH, CTRL_HEART: if (cmd == CMD_WAVE) return LEN_WAVE;
         CTRL_SLEEP: begin
            if (cmd == CMD_COMPOSITE) return LEN_COMP;
            if (cmd == CMD_NIGHT_REPORT) return LEN_NIGHT;
            if (cmd >= CMD_AWAKE_TIME && cmd <= CMD_DEEP_TIME) return $urandom_range(1, 2);
         end
         default: ;
      endcase
      return 1;
   endfunction

   task automatic test_random_frames(input int byte_goal);
      byte_q_type  f, data;
      int          kind, n, i, counted;
      logic [7:0]  ctrl, cmd;
      logic [15:0] len;
      counted = 0;
      while (counted < byte_goal) begin
         if ($urandom_range(0, 5) == 0) no_idle = !no_idle;
         kind = $urandom_range(0, 9);
         case ($urandom_range(0, 3))
            0: ctrl = CTRL_HUMAN;
            1: ctrl = CTRL_BREATH;
            2: ctrl = CTRL_SLEEP;
            default: ctrl = CTRL_HEART;
         endcase
         case (ctrl)
            CTRL_HUMAN:  cmd = 8'($urandom_range(CMD_PRESENCE, CMD_POSITION));
            CTRL_BREATH: cmd = 8'($urandom_range(CMD_BR_STATUS, CMD_WAVE));
            CTRL_SLEEP:  cmd = 8'($urandom_range(CMD_BED, CMD_NOPERSON));
            default:     cmd = $urandom_range(0, 1) ? CMD_HEART_RATE : CMD_WAVE;
         endcase
         if ($urandom_range(0, 19) == 0) ctrl = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 15) == 0) cmd = 8'($urandom_range(0, 255));
         n = payload_len(ctrl, cmd);
         len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 15)) : 16'(n);
         if (kind == 2) n += $urandom_range(10, 30);
         data.delete();
         // bed, state and quality bytes in their small legal range about half the time
         for (i = 0; i < n; i++)
            data.push_back((i < 2 && $urandom_range(0, 1)) ? 8'($urandom_range(0, 3))
                                                           : 8'($urandom_range(0, 255)));
         f = build_frame(ctrl, cmd, len, data);
         if (kind == 0) begin
            n = $urandom_range(1, 20);
            f.delete();
            for (i = 0; i < n; i++) f.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) f[0] = HDR0;
         end else if (kind == 1) begin
            n = $urandom_range(1, 8);
            while (f.size() > n) void'(f.pop_back());
         end else begin
            counted += f.size();
         end
         send_frame(f);
      end
   endtask

   // ---------------------------------------------------------------- result side

   function automatic void note_mismatch(string what, status_update_type want);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected id %0d value %0d last %0d, got id %0d value %0d last %0d",
                  what, want.field_id, want.value, want.last,
                  rsp_tdata[5:0], $signed(rsp_tdata[22:6]), rsp_tlast);
   endfunction

   always @(posedge clock) begin : check_updates
      status_update_type want;
      int                stall_left;
      if (reset) begin
         stall_left = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_updates.size() == 0) begin
               want = '{default: '0};
               note_mismatch("unexpected update", want);
            end else begin
               want = expected_updates.pop_front();
               if (rsp_tdata[5:0] != want.field_id || rsp_tdata[22:6] != want.value ||
                   rsp_tlast != want.last)
                  note_mismatch("update mismatch", want);
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 11);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_tready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : run
      int i;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      no_idle    = 1'b0;
      mismatches = 0;
      cycles     = 0;
      rx_count   = 0;
      for (i = 0; i < RSFD_FRAME_BYTES; i++) rx_store[i] = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_framing();
      test_human();
      test_breath();
      test_sleep();
      test_heart();
      test_frame_store();
      test_random_frames(RANDOM_BYTES / 2);
      wait_for_updates();
      test_random_frames(RANDOM_BYTES - RANDOM_BYTES / 2);
      wait_for_updates();

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
